// File: rtl/core/dffc_pkg.sv
package dffc_pkg;

  // Coefficient sets held in the constant ROM
  typedef enum logic [1:0] {
    COEF_FIR    = 2'd0,
    COEF_IIR_FF = 2'd1,
    COEF_IIR_FB = 2'd2
  } coef_set_t;

  // Control for one delay line: shift moves every cell by one place,
  // insert feeds new data at the head instead of wrapping the tail around
  typedef struct packed {
    logic shift;
    logic insert;
  } dffc_line_ctl_t;

  localparam int DATA_W   = 32;
  localparam int ROM_FRAC = 30;
  localparam int FIR_LEN  = 24;
  localparam int IIR_LEN  = 15;

  // Coefficients in Q30
  localparam longint FIR_ROM [0:FIR_LEN-1] = '{
    -64'sd2064806, -64'sd13338021, -64'sd26760867, -64'sd23143431, 64'sd8182557,
    64'sd39128226, 64'sd21367462, -64'sd46067819, -64'sd81289772, 64'sd10398438,
    64'sd216219391, 64'sd392431162, 64'sd392431162, 64'sd216219391, 64'sd10398438,
    -64'sd81289772, -64'sd46067819, 64'sd21367462, 64'sd39128226, 64'sd8182557,
    -64'sd23143431, -64'sd26760867, -64'sd13338021, -64'sd2064806
  };

  localparam longint IIR_FF_ROM [0:IIR_LEN-1] = '{
    64'sd1073741824, -64'sd4533123233, 64'sd10554774756, -64'sd16566762602,
    64'sd19227494842, -64'sd17176647959, 64'sd12075300553, -64'sd6738588939,
    64'sd2984465400, -64'sd1039586097, 64'sd279462785, -64'sd56066503,
    64'sd7917343, -64'sd703032, 64'sd29567
  };

  localparam longint IIR_FB_ROM [0:IIR_LEN-1] = '{
    64'sd5634, 64'sd78881, 64'sd512733, 64'sd2050954, 64'sd5640044,
    64'sd11279658, 64'sd16920024, 64'sd19337017, 64'sd16920024, 64'sd11279658,
    64'sd5640044, 64'sd2050954, 64'sd512733, 64'sd78881, 64'sd5634
  };

  // Round a Q30 value half away from zero to frac bits, wrap to 32 bits
  function automatic logic [DATA_W-1:0] quantize(longint q30, int frac);
    int     s;
    longint m;
    logic   neg;
    s   = ROM_FRAC - frac;
    neg = (q30 < 0);
    m   = neg ? -q30 : q30;
    if (s > 0) begin
      m = (m + (longint'(1) <<< (s - 1))) >>> s;
    end
    if (neg) begin
      m = -m;
    end
    return m[DATA_W-1:0];
  endfunction

  // Quantized coefficient of a set; taps past the set length read zero
  function automatic logic [DATA_W-1:0] coef_lookup(coef_set_t set, int idx, int frac);
    logic [DATA_W-1:0] c;
    c = '0;
    case (set)
      COEF_FIR: begin
        if (idx < FIR_LEN) c = quantize(FIR_ROM[idx], frac);
      end
      COEF_IIR_FF: begin
        if (idx < IIR_LEN) c = quantize(IIR_FF_ROM[idx], frac);
      end
      COEF_IIR_FB: begin
        if (idx < IIR_LEN) c = quantize(IIR_FB_ROM[idx], frac);
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/direct_form_fixed_point_filter_core.sv
// Direct-form-I fixed-point filter (signed 32-bit, FRACTION_BITS fraction bits).
// Each beat on the input channel is one integer sample; each output beat is one
// filtered value. One shared multiply-accumulate walks the taps: the feedforward
// and feedback delay lines are rings of cells that rotate one place per cycle
// while their taps are walked, presenting their tail to the multiplier. A
// sample steps through the feedforward taps, then the feedback taps (feedback
// on only), then a drain and a done state; no new sample is taken before the
// done state loads the result. The result sits in an output register, so a
// new sample is taken while it waits. cfg_feedback_enable selects pure FIR
// (0, reset) or IIR (1); write it only while the filter is idle.
module direct_form_fixed_point_filter_core #(
  parameter int FF_TAPS       = 24,
  parameter int FB_TAPS       = 15,
  parameter int FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_feedback_enable,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [23:0]          in_sample_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [dffc_pkg::DATA_W-1:0] out_filtered_out
);
  import dffc_pkg::*;

  localparam int MAXT  = (FF_TAPS > FB_TAPS) ? FF_TAPS : FB_TAPS;
  localparam int CNT_W = (MAXT > 1) ? $clog2(MAXT) : 1;
  localparam logic [CNT_W-1:0] FF_LAST = CNT_W'(FF_TAPS - 1);
  localparam logic [CNT_W-1:0] FB_LAST = CNT_W'(FB_TAPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FF,
    S_FB,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              fb_en_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic              accept;
  logic              out_free;
  logic [DATA_W-1:0] x_fixed;
  logic [DATA_W-1:0] ff_tail;
  logic [DATA_W-1:0] fb_tail;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [CNT_W-1:0]  ff_idx;
  logic [CNT_W-1:0]  fb_idx;
  dffc_line_ctl_t    ff_ctl;
  dffc_line_ctl_t    fb_ctl;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_en_r <= 1'b0;
    end else if (cfg_valid) begin
      fb_en_r <= cfg_feedback_enable;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_filtered_out = out_data_r;

  // integer sample to fixed point
  assign x_fixed = {{(DATA_W-24){in_sample_in[23]}}, in_sample_in} << FRACTION_BITS;

  // ring control: tail at rotation k holds entry (taps-1-k)
  always_comb begin
    ff_ctl.shift  = accept || (state_r == S_FF);
    ff_ctl.insert = accept;
    fb_ctl.shift  = (state_r == S_FB) || ((state_r == S_DONE) && out_free);
    fb_ctl.insert = (state_r == S_DONE);
  end

  assign ff_idx = FF_LAST - cnt_r;
  assign fb_idx = FB_LAST - cnt_r;

  // multiplier operands: delay-line tail and coefficient
  always_comb begin
    if (state_r == S_FF) begin
      mul_a = ff_tail;
      mul_b = coef_lookup(fb_en_r ? COEF_IIR_FF : COEF_FIR, int'(ff_idx), FRACTION_BITS);
    end else begin
      mul_a = fb_tail;
      mul_b = coef_lookup(COEF_IIR_FB, int'(fb_idx), FRACTION_BITS);
    end
  end

  dffc_delay_line #(.DEPTH(FF_TAPS)) u_ff_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ff_ctl),
    .new_data (x_fixed),
    .tail     (ff_tail)
  );

  dffc_delay_line #(.DEPTH(FB_TAPS)) u_fb_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fb_ctl),
    .new_data (acc),
    .tail     (fb_tail)
  );

  dffc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (accept),
    .valid ((state_r == S_FF) || (state_r == S_FB)),
    .sub   (state_r == S_FB),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (acc)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // beat leaves with no new result loaded behind it
      if (out_valid_r && out_ready && !((state_r == S_DONE) && out_free)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_FF;
            cnt_r   <= '0;
          end
        end
        S_FF: begin
          if (cnt_r == FF_LAST) begin
            cnt_r   <= '0;
            state_r <= fb_en_r ? S_FB : S_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FB: begin
          if (cnt_r == FB_LAST) begin
            cnt_r   <= '0;
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= acc;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/dffc_tap_cell.sv
module dffc_tap_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift,
  input  logic [dffc_pkg::DATA_W-1:0] din,
  output logic [dffc_pkg::DATA_W-1:0] dout
);
  import dffc_pkg::*;

  logic [DATA_W-1:0] q_r;

  // one history entry; takes its neighbor's value on shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= din;
    end
  end

  assign dout = q_r;

endmodule

// File: rtl/core/dffc_delay_line.sv
module dffc_delay_line #(
  parameter int DEPTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dffc_pkg::dffc_line_ctl_t    ctl,
  input  logic [dffc_pkg::DATA_W-1:0] new_data,
  output logic [dffc_pkg::DATA_W-1:0] tail
);
  import dffc_pkg::*;

  logic [DATA_W-1:0] link [0:DEPTH];

  // head takes the new sample, or the tail when the line rotates
  assign link[0] = ctl.insert ? new_data : link[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dffc_tap_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ctl.shift),
      .din   (link[i]),
      .dout  (link[i+1])
    );
  end

  assign tail = link[DEPTH];

endmodule

// File: rtl/core/dffc_mac.sv
module dffc_mac #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        valid,
  input  logic                        sub,
  input  logic [dffc_pkg::DATA_W-1:0] a,
  input  logic [dffc_pkg::DATA_W-1:0] b,
  output logic [dffc_pkg::DATA_W-1:0] acc
);
  import dffc_pkg::*;

  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic [DATA_W-1:0]          p_r;
  logic                       p_vld_r;
  logic                       p_sub_r;
  logic [DATA_W-1:0]          acc_r;

  // full product, truncated by arithmetic shift, low word kept
  assign prod    = $signed(a) * $signed(b);
  assign prod_sh = prod >>> FRACTION_BITS;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (clear) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid) begin
      p_r     <= prod_sh[DATA_W-1:0];
      p_sub_r <= sub;
    end
  end

  // wrapping accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (clear) begin
      acc_r <= '0;
    end else if (p_vld_r) begin
      acc_r <= p_sub_r ? (acc_r - p_r) : (acc_r + p_r);
    end
  end

  assign acc = acc_r;

endmodule
